// ----- hdl/hee_pkg.sv -----
// ----------------------------------------------------------------------------
// hee_pkg - shared types and tables for the HTML escape encoder
// Item classes, queue entry layout and the expansion tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hee_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_LT    = 8'h3c; // '<'
	localparam logic [7:0] CH_GT    = 8'h3e; // '>'
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26; // '&'
	localparam logic [7:0] CH_SEMI  = 8'h3b; // ';'
	localparam logic [7:0] CH_SLASH = 8'h2f; // '/'
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_P     = 8'h70;

	// what the back end emits for one queued item
	typedef enum logic [2:0] {
		CLS_PASS,   // the byte itself
		CLS_BR,     // "<br/>"
		CLS_LT,     // "&lt;"
		CLS_GT,     // "&gt;"
		CLS_NBSP    // "&nbsp;"
	} hee_cls_t;

	typedef struct packed {
		hee_cls_t   cls;
		logic [7:0] raw;
	} hee_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} hee_q_stat_t;

	// output byte count of a class
	function automatic logic [2:0] seq_len(input hee_cls_t cls);
		logic [2:0] n;
		case (cls)
			CLS_PASS: n = 3'd1;
			CLS_BR:   n = 3'd5;
			CLS_LT:   n = 3'd4;
			CLS_GT:   n = 3'd4;
			CLS_NBSP: n = 3'd6;
			default:  n = 3'd1;
		endcase
		return n;
	endfunction

	// byte number idx of the expansion of a class
	function automatic logic [7:0] seq_char(input hee_cls_t cls, input logic [2:0] idx,
		input logic [7:0] raw);
		logic [7:0] c;
		c = raw;
		case (cls)
			CLS_BR: begin
				case (idx)
					3'd0:    c = CH_LT;
					3'd1:    c = CH_B;
					3'd2:    c = CH_R;
					3'd3:    c = CH_SLASH;
					default: c = CH_GT;
				endcase
			end
			CLS_LT: begin
				case (idx)
					3'd0:    c = CH_AMP;
					3'd1:    c = CH_L;
					3'd2:    c = CH_T;
					default: c = CH_SEMI;
				endcase
			end
			CLS_GT: begin
				case (idx)
					3'd0:    c = CH_AMP;
					3'd1:    c = CH_G;
					3'd2:    c = CH_T;
					default: c = CH_SEMI;
				endcase
			end
			CLS_NBSP: begin
				case (idx)
					3'd0:    c = CH_AMP;
					3'd1:    c = CH_N;
					3'd2:    c = CH_B;
					3'd3:    c = CH_S;
					3'd4:    c = CH_P;
					default: c = CH_SEMI;
				endcase
			end
			default: c = raw;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/hee_channels.sv -----
// ----------------------------------------------------------------------------
// hee_channels - handshake channels of the HTML escape encoder
// Text input, encoded output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hee_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface hee_cfg_if;
	logic valid;
	logic ready;
	logic nbsp_enable;
	modport source (output valid, output nbsp_enable, input ready);
	modport sink   (input valid, input nbsp_enable, output ready);
endinterface

`default_nettype wire

// ----- hdl/hee_front.sv -----
// ----------------------------------------------------------------------------
// hee_front - classifier
// Sorts each accepted byte into an expansion class and tracks line breaks.
// ----------------------------------------------------------------------------
`default_nettype none

module hee_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              end_of_text,
	input  wire logic              nbsp_enable,
	output logic                   push,
	output hee_pkg::hee_item_t     item
);

	logic prev_break_q;
	logic is_break;
	logic drop;

	assign is_break = (in_byte == hee_pkg::CH_CR) || (in_byte == hee_pkg::CH_LF);
	// repeated break: consumed, nothing queued
	assign drop     = is_break && prev_break_q;
	assign push     = accept && !drop;

	always_comb begin
		item.raw = in_byte;
		if (is_break) begin
			item.cls = hee_pkg::CLS_BR;
		end else if (in_byte == hee_pkg::CH_LT) begin
			item.cls = hee_pkg::CLS_LT;
		end else if (in_byte == hee_pkg::CH_GT) begin
			item.cls = hee_pkg::CLS_GT;
		end else if (in_byte == hee_pkg::CH_SPACE && nbsp_enable) begin
			item.cls = hee_pkg::CLS_NBSP;
		end else begin
			item.cls = hee_pkg::CLS_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_break_q <= 1'b0;
		end else if (accept) begin
			prev_break_q <= is_break && !end_of_text;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/hee_queue.sv -----
// ----------------------------------------------------------------------------
// hee_queue - item queue between classifier and expander
// Small register FIFO; push is refused while full.
// ----------------------------------------------------------------------------
`default_nettype none

module hee_queue #(
	parameter int DEPTH = hee_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hee_pkg::hee_item_t wdata,
	input  wire logic               pop,
	output hee_pkg::hee_item_t      rdata,
	output hee_pkg::hee_q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hee_pkg::hee_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/hee_back.sv -----
// ----------------------------------------------------------------------------
// hee_back - expander
// Walks the head item's expansion one output byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hee_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire hee_pkg::hee_item_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   run_last
);

	logic [2:0] idx_q;
	logic       fire;

	assign out_valid = head_valid;
	assign out_byte  = hee_pkg::seq_char(head.cls, idx_q, head.raw);
	assign run_last  = (idx_q == hee_pkg::seq_len(head.cls) - 3'd1);
	assign fire      = out_valid && out_ready;
	assign pop       = fire && run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= run_last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/html_escape_encoder.sv -----
// ----------------------------------------------------------------------------
// html_escape_encoder - streaming HTML escape encoder
// Turns a text byte stream into its HTML-escaped form, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  text      in   valid/ready    in_byte[7:0], end_of_text
//  encoded   out  valid/ready    out_byte[7:0], run_last
//  cfg       in   valid/ready    nbsp_enable (always ready)
//
//  Plain bytes go through as one output byte each, back to back. A tag or
//  entity holds the expander for 4 to 6 output bytes (one per cycle while
//  the output is ready); input keeps being taken until the item queue
//  fills, so the output port's one byte per cycle sets the sustained rate.
//  Collapsed line breaks are taken in and give no output. arst_n clears
//  the queue, the expander position, the line-break flag and nbsp_enable.
// ----------------------------------------------------------------------------
`default_nettype none

module html_escape_encoder #(
	parameter int QUEUE_DEPTH = hee_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hee_in_if.sink      text,
	hee_out_if.source   encoded,
	hee_cfg_if.sink     cfg
);

	logic                  nbsp_q;
	logic                  text_fire;
	logic                  q_push;
	logic                  q_pop;
	hee_pkg::hee_item_t    push_item;
	hee_pkg::hee_item_t    head_item;
	hee_pkg::hee_q_stat_t  q_stat;

	// configuration: single register, written whenever offered
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbsp_q <= 1'b0;
		end else if (cfg.valid) begin
			nbsp_q <= cfg.nbsp_enable;
		end
	end

	// front end takes a byte whenever the queue has a free slot
	assign text.ready = !q_stat.full;
	assign text_fire  = text.valid && text.ready;

	hee_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (text_fire),
		.in_byte     (text.in_byte),
		.end_of_text (text.end_of_text),
		.nbsp_enable (nbsp_q),
		.push        (q_push),
		.item        (push_item)
	);

	hee_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_item),
		.pop    (q_pop),
		.rdata  (head_item),
		.stat   (q_stat)
	);

	// back end drains the head item onto the output port
	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_stat.empty),
		.head       (head_item),
		.pop        (q_pop),
		.out_valid  (encoded.valid),
		.out_ready  (encoded.ready),
		.out_byte   (encoded.out_byte),
		.run_last   (encoded.run_last)
	);

`ifndef SYNTHESIS
	// a push is never offered into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("push into full queue");

	// an escaped '<' always reaches the queue
	a_lt_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(text_fire && text.in_byte == hee_pkg::CH_LT) |-> q_push)
		else $error("'<' not queued");

	// mid-expansion the next byte is already pending
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(encoded.valid && encoded.ready && !encoded.run_last) |=> encoded.valid)
		else $error("expansion broken off");
`endif

endmodule

`default_nettype wire
